[src/mbox_from_line_escaper_assert.svh]
// Assertion macros for the mbox From-line escaper checker.
// No dependencies; included by the checker file.
`ifndef MBOX_FROM_LINE_ESCAPER_ASSERT_SVH
`define MBOX_FROM_LINE_ESCAPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checker: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define MFLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checker: next-cycle property violated");

`endif

[src/mfle_pkg.sv]
// Shared types, constants and functions for the mbox From-line escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mfle_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChFour    = 8'h34;
  localparam logic [7:0] ChSix     = 8'h36;
  localparam logic [7:0] ChF       = 8'h46;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChO       = 8'h6F;
  localparam logic [7:0] ChM       = 8'h6D;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam logic [2:0] PrefixLast = 3'd4;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_HELD   = 2'd1,
    CMD_ESC_GT = 2'd2,
    CMD_ESC_QP = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  held;
    logic [7:0]  data;
    logic        eos;
  } cmd_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = ChF;
      3'd1:    ch = ChR;
      3'd2:    ch = ChO;
      3'd3:    ch = ChM;
      3'd4:    ch = ChSpace;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[src/mbox_from_line_escaper.sv]
// Top level of the mbox From-line escaper: front, command queue and back.
// Depends on mfle_pkg, mfle_front, mfle_fifo and mfle_back.
//
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tdata: in_byte[7:0]; tlast: end_of_stream
// m_axis   | out | tdata: out_byte[7:0]; tuser: run_last; tlast: stream_last
// cfg      | in  | cfg_data_i: armor_mode
//
// The back part emits one byte per cycle from its output register while
// the output is not stalled. A plain byte gives one output byte, after any
// held prefix bytes; an escape six or seven, and a flushed prefix up to four.
// The input keeps taking bytes while an escape drains and stalls only when
// the command queue is full.
// Reset puts the block at line start with nothing held and armor mode off.
`timescale 1ns / 1ps
`default_nettype none

module mbox_from_line_escaper
  import mfle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // in_byte[7:0]
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // out_byte[7:0]
  output logic            m_axis_tuser,  // run_last
  output logic            m_axis_tlast
);

  logic armor_q;
  logic full, empty, push, pop;
  cmd_t push_cmd, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armor_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      armor_q <= cfg_data_i;
    end
  end

  mfle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .armor_i       (armor_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  mfle_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  mfle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[src/mfle_fifo.sv]
// Small command queue between the front and back parts of the escaper.
// Depends on mfle_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module mfle_fifo
  import mfle_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[src/mfle_front.sv]
// Front part: accepts input bytes, tracks line start and the held prefix,
// and turns each byte into an output command. Depends on mfle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfle_front
  import mfle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       armor_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tlast,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic       line_start_q, line_start_d;
  logic [2:0] held_q, held_d;
  logic       accept, match, has_cmd;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign match         = line_start_q && (s_axis_tdata == prefix_byte(held_q));
  assign push_o        = accept && has_cmd;

  always_comb begin
    cmd_o.kind   = CMD_BYTE;
    cmd_o.held   = 3'd0;
    cmd_o.data   = s_axis_tdata;
    cmd_o.eos    = s_axis_tlast;
    has_cmd      = 1'b1;
    held_d       = 3'd0;
    line_start_d = (s_axis_tdata == ChNewline);
    if (!line_start_q) begin
      cmd_o.kind = CMD_BYTE;
    end else if (match && (held_q == PrefixLast)) begin
      cmd_o.kind   = armor_i ? CMD_ESC_QP : CMD_ESC_GT;
      line_start_d = 1'b0;
    end else if (match) begin
      // A partial match is held; a mismatch or stream end releases it.
      held_d       = held_q + 3'd1;
      line_start_d = 1'b1;
      cmd_o.kind   = CMD_HELD;
      cmd_o.held   = held_q + 3'd1;
      has_cmd      = s_axis_tlast;
    end else begin
      cmd_o.kind = CMD_BYTE;
      cmd_o.held = held_q;
    end
    if (s_axis_tlast) begin
      held_d       = 3'd0;
      line_start_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      held_q       <= 3'd0;
    end else if (accept) begin
      line_start_q <= line_start_d;
      held_q       <= held_d;
    end
  end

endmodule

`default_nettype wire

[src/mfle_back.sv]
// Back part: expands queued commands into output bytes, one per cycle,
// unless stalled, from a registered output stage. Depends on mfle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfle_back
  import mfle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t head_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic      m_axis_tuser,
  output logic      m_axis_tlast
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] len;
  logic [7:0] cur_byte;
  logic       is_last, load;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q;
  logic       out_run_last_q, out_stream_last_q;

  always_comb begin
    unique case (head_i.kind)
      CMD_BYTE:   len = head_i.held + 3'd1;
      CMD_HELD:   len = head_i.held;
      CMD_ESC_GT: len = 3'd6;
      CMD_ESC_QP: len = 3'd7;
      default:    len = 3'd1;
    endcase
  end

  always_comb begin
    unique case (head_i.kind)
      CMD_BYTE:   cur_byte = (idx_q < head_i.held) ? prefix_byte(idx_q) : head_i.data;
      CMD_HELD:   cur_byte = prefix_byte(idx_q);
      CMD_ESC_GT: cur_byte = (idx_q == 3'd0) ? ChGt : prefix_byte(idx_q - 3'd1);
      CMD_ESC_QP: begin
        case (idx_q)
          3'd0:    cur_byte = ChEq;
          3'd1:    cur_byte = ChFour;
          3'd2:    cur_byte = ChSix;
          default: cur_byte = prefix_byte(idx_q - 3'd2);
        endcase
      end
      default:    cur_byte = head_i.data;
    endcase
  end

  assign is_last = (idx_q == (len - 3'd1));
  assign load    = !empty_i && (!out_valid_q || m_axis_tready);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q        <= cur_byte;
      out_run_last_q    <= is_last;
      out_stream_last_q <= is_last && head_i.eos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_run_last_q;
  assign m_axis_tlast  = out_stream_last_q;

endmodule

`default_nettype wire

[src/mfle_checker.sv]
// Port-level checker for the mbox From-line escaper, bound to the top level.
// Depends on mbox_from_line_escaper_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "mbox_from_line_escaper_assert.svh"

module mfle_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser,
  input wire logic       m_axis_tlast
);

  logic       out_stall;
  logic [9:0] out_beat;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // A stalled output transaction keeps its valid.
  `MFLE_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_stall, m_axis_tvalid)

  // The final byte of a stream is always the last byte of its run.
  `MFLE_ASSERT_SAME(a_stream_end_ends_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

  // The register port never stalls a write.
  `MFLE_ASSERT_SAME(a_cfg_always_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

  // A stalled output transaction keeps its payload.
  `MFLE_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_stall, $stable(out_beat))

endmodule

bind mbox_from_line_escaper mfle_checker u_checker (.*);

`default_nettype wire
